[rtl/sat_pkg.sv]
// Shared types and constants of the symbol address table.
package sat_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned SlotW         = 8;
  localparam int unsigned FuncW         = 2;

  typedef enum logic [FuncW-1:0] {
    FuncInsert = 2'd0,
    FuncExact  = 2'd1,
    FuncBelow  = 2'd2
  } sat_func_e;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] entry_addr;
    logic             full_res;
  } sat_res_t;

endpackage

[rtl/symbol_address_table_core.sv]
// Top level of the symbol address table.
//
// Append-only table of function start addresses with exact and
// nearest-lower lookup. One result word per input word.
// Input channel: tuser selects the operation (insert, exact, nearest
// lower), tdata carries the address. Output channel: tdata carries hit,
// slot, stored address and the table-full flag.
// An insert's result is registered in the sequencer and then in the
// output register. A lookup reads the entry store once per filled
// slot (up to TABLE_DEPTH), one entry a cycle through the single read
// port; on an empty table it skips the scan.
// One word is worked on at a time; the next input word is taken once
// the previous result has moved into the output register.
// Reset empties the table (fill count to zero) and drops any pending
// result. When the receiver stalls, the result holds in the output
// register and the sequencer waits with the next result behind it.
module symbol_address_table_core import sat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] addr
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // [0] hit, [8:1] slot, [72:9] entry_addr, [73] full_res
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic             wr_en, rd_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  logic [AddrW-1:0] wr_data, rd_data;
  logic             res_valid, res_ready;
  sat_res_t         res, out_res;

  sat_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sat_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_addr_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  sat_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.full_res, out_res.entry_addr, out_res.slot, out_res.hit};

endmodule

[rtl/sat_mem.sv]
// Entry store: one write port, one read port with registered read data.
module sat_mem import sat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [AddrW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [AddrW-1:0] rd_data_o
);

  logic [AddrW-1:0] mem_q [TABLE_DEPTH];
  logic [AddrW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/sat_ctrl.sv]
// Sequencer: appends entries and scans the store one entry a cycle for lookups.
module sat_ctrl import sat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] in_func_i,
  input  logic [AddrW-1:0] in_addr_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sat_res_t         res_o,
  output logic             wr_en_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output logic [AddrW-1:0] wr_data_o,
  output logic             rd_en_o,
  output logic [IdxW-1:0]  rd_addr_o,
  input  logic [AddrW-1:0] rd_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  localparam logic [CntW-1:0] Full = CntW'(TABLE_DEPTH);

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [FuncW-1:0] op_q, op_d;
  logic [AddrW-1:0] query_q, query_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             rv_q, rv_d;
  logic [IdxW-1:0]  tag_q, tag_d;
  logic             found_q, found_d;
  logic [AddrW-1:0] best_q, best_d;
  logic [IdxW-1:0]  best_slot_q, best_slot_d;
  logic [AddrW-1:0] first_q, first_d;
  sat_res_t         res_q, res_d;
  logic             issue;

  assign issue = (state_q == StScan) && (rd_idx_q != n_q);

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StFin);
  assign res_o       = res_q;
  assign rd_en_o     = issue;
  assign rd_addr_o   = rd_idx_q[IdxW-1:0];
  assign wr_addr_o   = count_q[IdxW-1:0];
  assign wr_data_o   = in_addr_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    op_d        = op_q;
    query_d     = query_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    rv_d        = issue;
    tag_d       = rd_idx_q[IdxW-1:0];
    found_d     = found_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    first_d     = first_q;
    res_d       = res_q;
    wr_en_o     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d        = in_func_i;
          query_d     = in_addr_i;
          n_d         = count_q;
          rd_idx_d    = '0;
          found_d     = 1'b0;
          best_d      = '0;
          best_slot_d = '0;
          first_d     = '0;
          res_d       = '0;
          state_d     = StFin;
          unique case (sat_func_e'(in_func_i))
            FuncInsert: begin
              if (count_q == Full) begin
                res_d.full_res = 1'b1;
              end else begin
                wr_en_o          = 1'b1;
                count_d          = count_q + CntW'(1);
                res_d.slot       = SlotW'(count_q[IdxW-1:0]);
                res_d.entry_addr = in_addr_i;
              end
            end
            FuncExact, FuncBelow: begin
              if (count_q != '0) begin
                state_d = StScan;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rv_q) begin
          if (tag_q == '0) begin
            first_d = rd_data_i;
          end
          if (op_q == FuncExact) begin
            if (!found_q && rd_data_i == query_q) begin
              found_d     = 1'b1;
              best_d      = rd_data_i;
              best_slot_d = tag_q;
            end
          end else if (rd_data_i < query_q && rd_data_i > best_q) begin
            found_d     = 1'b1;
            best_d      = rd_data_i;
            best_slot_d = tag_q;
          end
        end
        if (!issue && !rv_q) begin
          state_d = StFin;
          if (found_q) begin
            res_d.hit        = 1'b1;
            res_d.slot       = SlotW'(best_slot_q);
            res_d.entry_addr = best_q;
          end else if (op_q == FuncBelow) begin
            res_d.entry_addr = first_q;
          end
        end
      end
      StFin: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    query_q     <= query_d;
    n_q         <= n_d;
    rd_idx_q    <= rd_idx_d;
    tag_q       <= tag_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
    first_q     <= first_d;
    res_q       <= res_d;
  end

endmodule

[rtl/sat_obuf.sv]
// Output register between the sequencer and the result channel.
module sat_obuf import sat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  output logic     res_ready_o,
  input  sat_res_t res_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sat_res_t out_o
);

  logic     valid_q, valid_d;
  sat_res_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign valid_d     = res_valid_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule

[rtl/sat_chk.sv]
// Port-level checks of the symbol address table, bound to the top level.
module sat_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_hit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[73]))
    else $error("hit and full flagged together");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input word taken while one is in work");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[73] |-> m_axis_tdata[72:1] == '0)
    else $error("refused insert carries slot or address");

endmodule

bind symbol_address_table_core sat_chk u_chk (.*);
